// ----- hw/rtl/tmavg_pkg.sv -----
// tmavg_pkg: shared types and constants for the three-axis moving average
// used by the channel interfaces, the top level and the checker
package tmavg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int AXES     = 3;

  // axis order inside a packed window entry and the per-axis arrays
  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ----- hw/rtl/tmavg_if.sv -----
// tmavg_in_if / tmavg_out_if: valid/ready channels for samples and means
// depends on tmavg_pkg for the sample type
interface tmavg_in_if import tmavg_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_x;
  sample_t sample_y;
  sample_t sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

interface tmavg_out_if import tmavg_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t mean_x;
  sample_t mean_y;
  sample_t mean_z;

  modport source (output valid, output mean_x, output mean_y, output mean_z,
                  input ready);
  modport sink   (input valid, input mean_x, input mean_y, input mean_z,
                  output ready);
endinterface

// ----- hw/rtl/tmavg_ram.sv -----
// tmavg_ram: generic single-write, single-read ram with registered read
// no package dependency
module tmavg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/three_axis_moving_average_top.sv -----
// three_axis_moving_average_top: boxcar mean over the last WINDOW samples per axis
// pipeline from input transaction to result transaction: ram read, sum, multiply, divide
// fix-up, with out valid driven from a register
// throughput: one transaction per cycle unless out stalls; ram read once, written once per item
// reset (rst_n low, synchronous): pointer, running sums, entry valid bits and all stage
// valids cleared; entries not yet written read as zero through their valid bits
module three_axis_moving_average_top import tmavg_pkg::*; #(
  parameter int WINDOW = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  tmavg_in_if.sink     in_chan,
  tmavg_out_if.source  out_chan
);

  localparam int PTR_W   = $clog2(WINDOW);
  // running sum: sample width plus growth for WINDOW terms
  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int PROD_W  = 2 * SUM_W;
  localparam int ENTRY_W = AXES * SAMPLE_W;
  // reciprocal floor(2^SUM_W / WINDOW); estimate is exact or one low
  localparam longint unsigned RECIP_L = (64'd1 << SUM_W) / WINDOW;
  localparam logic [SUM_W-1:0] RECIP  = RECIP_L[SUM_W-1:0];
  localparam logic [SUM_W-1:0] WIN_C  = SUM_W'(WINDOW);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  // ---------------------------------------------------------------------------
  // handshake / stage advance
  // each stage loads when empty or when its content moves on, so bubbles collapse
  // and a waiting result blocks new transactions only when all stages behind it are full
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic ld_out, ld_s3, ld_s2, in_acc;

  assign ld_out        = s3_v_r && (!out_v_r || out_chan.ready);
  assign ld_s3         = s2_v_r && (!s3_v_r || ld_out);
  assign ld_s2         = s1_v_r && (!s2_v_r || ld_s3);
  assign in_chan.ready = !s1_v_r || ld_s2;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // ---------------------------------------------------------------------------
  // window store: one entry per slot, all three axes packed
  // ---------------------------------------------------------------------------
  logic [PTR_W-1:0]   ptr_r;
  logic [WINDOW-1:0]  vld_r;      // slot written since reset
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;

  sample_t in_smp [AXES];
  assign in_smp[AX_X] = in_chan.sample_x;
  assign in_smp[AX_Y] = in_chan.sample_y;
  assign in_smp[AX_Z] = in_chan.sample_z;

  // stage 1: sample waiting for the evicted entry to come out of the ram
  sample_t          s1_smp_r [AXES];
  logic [PTR_W-1:0] s1_slot_r;
  logic             s1_ok_r;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      wr_data[a*SAMPLE_W +: SAMPLE_W] = s1_smp_r[a];
    end
  end

  // a slot is read again only WINDOW transactions after its write, so the read
  // never overlaps the pending write-back
  tmavg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW)
  ) u_win_ram (
    .clk   (clk),
    .we    (ld_s2),
    .waddr (s1_slot_r),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (ptr_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        ptr_r  <= (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
        s1_v_r <= 1'b1;
      end else if (ld_s2) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_smp_r  <= in_smp;
      s1_slot_r <= ptr_r;
      s1_ok_r   <= vld_r[ptr_r];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: running sum update, new sample written back to the evicted slot
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_r     [AXES];
  logic signed [SUM_W-1:0] sum_nxt   [AXES];
  logic signed [SUM_W-1:0] s2_sum_r  [AXES];
  sample_t                 old_smp   [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      // never-written slots count as zero through their valid bit
      old_smp[a] = s1_ok_r ? sample_t'(rd_data[a*SAMPLE_W +: SAMPLE_W]) : '0;
      sum_nxt[a] = sum_r[a] + SUM_W'(s1_smp_r[a]) - SUM_W'(old_smp[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      s2_v_r <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_r[a] <= '0;
      end
    end else begin
      if (ld_s2) begin
        vld_r[s1_slot_r] <= 1'b1;
        sum_r            <= sum_nxt;
        s2_v_r           <= 1'b1;
      end else if (ld_s3) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_s2) begin
      s2_sum_r <= sum_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: magnitude times reciprocal (sign kept aside, truncation toward zero)
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]  mag      [AXES];
  logic [PROD_W-1:0] prod     [AXES];
  logic [SUM_W-1:0]  s3_mag_r [AXES];
  logic [PROD_W-1:0] s3_prod_r[AXES];
  logic              s3_neg_r [AXES];
  logic              neg      [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      neg[a]  = s2_sum_r[a][SUM_W-1];
      mag[a]  = neg[a] ? SUM_W'(-s2_sum_r[a]) : SUM_W'(s2_sum_r[a]);
      prod[a] = PROD_W'(mag[a]) * PROD_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      if (ld_s3) begin
        s3_v_r <= 1'b1;
      end else if (ld_out) begin
        s3_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_s3) begin
      s3_mag_r  <= mag;
      s3_prod_r <= prod;
      s3_neg_r  <= neg;
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: quotient fix-up by one, sign restored, result register
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] q_est [AXES];
  logic [SUM_W-1:0] rem   [AXES];
  logic [SUM_W-1:0] quo   [AXES];
  sample_t          mean  [AXES];
  sample_t          out_mean_r [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      q_est[a] = s3_prod_r[a][PROD_W-1 -: SUM_W];
      rem[a]   = s3_mag_r[a] - SUM_W'(q_est[a] * WIN_C);
      quo[a]   = (rem[a] >= WIN_C) ? q_est[a] + 1'b1 : q_est[a];
      mean[a]  = s3_neg_r[a] ? sample_t'(SAMPLE_W'(-quo[a])) : sample_t'(SAMPLE_W'(quo[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      if (ld_out) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_mean_r <= mean;
    end
  end

  assign out_chan.valid  = out_v_r;
  assign out_chan.mean_x = out_mean_r[AX_X];
  assign out_chan.mean_y = out_mean_r[AX_Y];
  assign out_chan.mean_z = out_mean_r[AX_Z];

endmodule

// ----- hw/rtl/tmavg_chk.sv -----
// tmavg_chk: port-level checks on the moving average top, bound to every instance
// depends on tmavg_pkg and three_axis_moving_average_top
module tmavg_chk import tmavg_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t mean_x,
  input sample_t mean_y,
  input sample_t mean_z
);

  logic       in_acc, out_acc;
  logic [2:0] inflight_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  // four stages hold at most four transactions
  a_inflight_max: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd4)
    else $error("more transactions in flight than pipeline stages");

  // a result only ever follows an accepted sample
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (inflight_r == 3'd0) |-> !out_valid)
    else $error("result shown with nothing in flight");

  // with the sink ready while it passes through the stages, an accepted sample yields a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mean_x) && $stable(mean_y)
                                && $stable(mean_z))
    else $error("stalled result changed");

endmodule

bind three_axis_moving_average_top tmavg_chk u_tmavg_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .mean_x    (out_chan.mean_x),
  .mean_y    (out_chan.mean_y),
  .mean_z    (out_chan.mean_z)
);

// ----- tb/tmavg_checker.sv -----
// tmavg_checker: watches both channels of the three-axis moving average, predicts the
// per-axis window mean of every accepted sample and compares it with each accepted result
// depends on tmavg_pkg and the channel interfaces in tmavg_if
module tmavg_checker import tmavg_pkg::*; #(
  parameter int WINDOW = 15
) (
  input  logic  clk,
  input  logic  rst_n,
  tmavg_in_if   in_mon,
  tmavg_out_if  out_mon,
  output int    mismatches,
  output int    pending,
  output int    results_checked
);

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } mean_triple_t;

  // predictor state: circular window per axis, running sums, slot to overwrite next
  sample_t      hist [WINDOW][AXES];
  int           axis_sum [AXES];
  int           next_slot;
  mean_triple_t means_due [$];
  int           fail_tally = 0;
  int           check_tally = 0;

  function automatic mean_triple_t slide_window(sample_t sx, sample_t sy, sample_t sz);
    sample_t      incoming [AXES];
    int           quot [AXES];
    mean_triple_t m;
    incoming[AX_X] = sx;
    incoming[AX_Y] = sy;
    incoming[AX_Z] = sz;
    for (int a = 0; a < AXES; a++) begin
      axis_sum[a] += int'(incoming[a]) - int'(hist[next_slot][a]);
      hist[next_slot][a] = incoming[a];
      // signed int division truncates toward zero
      quot[a] = axis_sum[a] / WINDOW;
    end
    next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
    m.x = sample_t'(quot[AX_X]);
    m.y = sample_t'(quot[AX_Y]);
    m.z = sample_t'(quot[AX_Z]);
    return m;
  endfunction

  task automatic check_axis(input string axis_name, input sample_t want, input sample_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, axis_name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    mean_triple_t want;
    if (!rst_n) begin
      for (int s = 0; s < WINDOW; s++) begin
        for (int a = 0; a < AXES; a++) begin
          hist[s][a] = '0;
        end
      end
      for (int a = 0; a < AXES; a++) begin
        axis_sum[a] = 0;
      end
      next_slot = 0;
      means_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (means_due.size() == 0) begin
          $display("%0t: result with no sample outstanding, actual %0d %0d %0d", $time,
                   out_mon.mean_x, out_mon.mean_y, out_mon.mean_z);
          fail_tally++;
        end else begin
          want = means_due.pop_front();
          check_axis("mean_x", want.x, out_mon.mean_x);
          check_axis("mean_y", want.y, out_mon.mean_y);
          check_axis("mean_z", want.z, out_mon.mean_z);
          check_tally++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        means_due.push_back(slide_window(in_mon.sample_x, in_mon.sample_y, in_mon.sample_z));
      end
    end
    mismatches      <= fail_tally;
    pending         <= means_due.size();
    results_checked <= check_tally;
  end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for three_axis_moving_average_top
// drives samples with random source gaps and sink stalls; checking lives in tmavg_checker
// depends on tmavg_pkg, tmavg_if, the block itself and tb/tmavg_checker.sv
module tb_top;
  import tmavg_pkg::*;

  localparam int WINDOW          = 15;
  localparam int ITEMS_PER_PHASE = 334;
  localparam int PHASES          = 3;
  // settle margin after the last drain for stray results
  localparam int SETTLE_CYCLES   = 16;
  // slowest correct run is roughly 1000 transactions under heavy stalls, far
  // below this limit
  localparam int LIMIT_TIME      = 2_000_000;

  localparam sample_t S_MAX = 16'sh7fff;
  localparam sample_t S_MIN = 16'sh8000;

  logic clk = 1'b0;
  logic rst_n;

  // percentage of cycles in which the source holds back or the sink stalls
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int send_pct_by_phase [PHASES] = '{32, 87, 0};
  int take_pct_by_phase [PHASES] = '{87, 32, 0};

  int samples_sent = 0;
  int mismatches;
  int pending;
  int results_checked;

  tmavg_in_if  in_chan ();
  tmavg_out_if out_chan ();

  three_axis_moving_average_top #(.WINDOW(WINDOW)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  tmavg_checker #(.WINDOW(WINDOW)) chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // 10 unit period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sink side: ready re-drawn every cycle from the current stall percentage
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // one sample transaction; random gaps before it, then hold until accepted
  task automatic send_sample(input sample_t sx, input sample_t sy, input sample_t sz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.sample_x <= sx;
    in_chan.sample_y <= sy;
    in_chan.sample_z <= sz;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    samples_sent++;
  endtask

  // source goes quiet until every predicted mean has come back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // mix of full-scale extremes, values near zero (truncation of small negative
  // sums) and fully random words so every bit toggles
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3:    return sample_t'(int'($urandom_range(40)) - 20);
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.sample_x <= '0;
    in_chan.sample_y <= '0;
    in_chan.sample_z <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: start-up with empty entries counting as zeros, and
    // truncation toward zero of small negative and positive sums
    take_idle_pct = 30;
    send_sample(sample_t'(-1), sample_t'(1), sample_t'(-14));
    send_sample(sample_t'(-16), sample_t'(16), sample_t'(-30));
    // fill the whole window with extremes so the means reach full scale,
    // z alternating between the two ends
    for (int i = 0; i < 16; i++) begin
      send_sample(S_MAX, S_MIN, i[0] ? S_MAX : S_MIN);
    end
    // swing to the opposite extremes while the old ones are still evicted
    for (int i = 0; i < 7; i++) begin
      send_sample(S_MIN, S_MAX, '0);
    end
    // source holds off until the pipeline is empty
    drain_results();

    // random phases: heavy sink stalls, then heavy source gaps, then full rate
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = send_pct_by_phase[p];
      take_idle_pct = take_pct_by_phase[p];
      repeat (ITEMS_PER_PHASE) send_sample(pick_sample(), pick_sample(), pick_sample());
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d sample transactions, %0d window means compared on all three axes",
             samples_sent, results_checked);
    $display("covered start-up zeros, full-scale extremes and three source/sink stall mixes");
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_TIME);
    $display("timeout with %0d means outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule
